/* hdl/mmrf_pkg.sv */
// ----------------------------------------------------------------------------
// mmrf_pkg: shared types and constants of the masked median row filter
// Window geometry, queue sizing, register indexes and the structs passed
// between the front end, the job queue and the back end.
// ----------------------------------------------------------------------------
package mmrf_pkg;

  // sample and window geometry
  localparam int PixBits  = 16;
  localparam int WinLen   = 11;
  localparam int Half     = (WinLen - 1) / 2;
  localparam int PosBits  = 13;
  localparam int PosCap   = 4096;
  localparam int RowsBits = 13;
  localparam int RowsReset = 4096;
  localparam int CfgBits  = 16;
  localparam int CfgIdxBits = 2;

  // rank of one sample among the window, 0..WinLen-1
  localparam int RankBits  = $clog2(WinLen + 1);
  // beats per job: up to one centre beat plus up to Half flush beats
  localparam int FlushBits = $clog2(Half + 2);
  localparam int TailBits  = $clog2(Half);

  // job queue between front and back
  localparam int FifoDepth   = 4;
  localparam int FifoPtrBits = $clog2(FifoDepth);
  localparam int FifoCntBits = $clog2(FifoDepth + 1);

  // rows open inside the block: queue entries plus pipeline stages
  localparam int PendBits = $clog2(FifoDepth + 4);

  typedef logic [PixBits-1:0] pix_t;

  // register indexes of the write port
  typedef enum logic [CfgIdxBits-1:0] {
    REG_MARKER_ENABLE  = 2'd0,
    REG_MARKER_VALUE   = 2'd1,
    REG_MARKER_REPLACE = 2'd2,
    REG_REGION_ROWS    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                marker_enable;
    pix_t                marker_value;
    pix_t                marker_replace;
    logic [RowsBits-1:0] region_rows;
  } cfg_t;

  // one classified input beat: window after the shift and what to emit
  typedef struct packed {
    logic [WinLen-1:0][PixBits-1:0] win;
    logic                           has_main;  // emit the delayed centre pixel
    logic                           filt;      // centre gets the median
    logic [FlushBits-1:0]           nflush;    // tail pixels flushed at row end
  } job_t;

endpackage

/* hdl/masked_median_row_filter.sv */
// ----------------------------------------------------------------------------
// masked_median_row_filter: 11-tap horizontal median with marker masking
// Top level: configuration registers, front end, job queue, back end.
// ----------------------------------------------------------------------------
// Pixels stream in row by row at one beat per clock and come out five
// positions late, at one beat per clock while res_stall is low; the first
// and last five pixels of a row, rows shorter than eleven and regions under
// eleven rows pass unchanged, the rest get the (optionally marker-masked,
// upper) median of their eleven-pixel window. A row_end beat releases the
// rest of the row, so it yields up to six result beats, sent one per clock
// from the single output register unless res_stall holds them; the input
// keeps flowing meanwhile into a four-entry job queue and is stalled only
// when that queue fills. Each beat passes the queue, compare, rank and
// output stages on its way out. Write the registers only while idle.
// ----------------------------------------------------------------------------
module masked_median_row_filter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mmrf_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [mmrf_pkg::CfgBits-1:0]    cfg_data,
  input  logic [mmrf_pkg::PixBits-1:0]    pixel_in,
  input  logic                            row_end,
  input  logic                            pix_valid,
  output logic                            pix_stall,
  output logic [mmrf_pkg::PixBits-1:0]    pixel_out,
  output logic                            row_done,
  output logic                            res_valid,
  input  logic                            res_stall
);
  import mmrf_pkg::*;

  cfg_t  cfg;
  job_t  push_job;
  job_t  head_job;
  logic  push;
  logic  fifo_full;
  logic  fifo_valid;
  logic  job_ready;
  logic  fifo_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.marker_enable  <= 1'b0;
      cfg.marker_value   <= '0;
      cfg.marker_replace <= '0;
      cfg.region_rows    <= RowsBits'(RowsReset);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MARKER_ENABLE:  cfg.marker_enable  <= cfg_data[0];
        REG_MARKER_VALUE:   cfg.marker_value   <= cfg_data[PixBits-1:0];
        REG_MARKER_REPLACE: cfg.marker_replace <= cfg_data[PixBits-1:0];
        REG_REGION_ROWS:    cfg.region_rows    <= cfg_data[RowsBits-1:0];
        default: begin
        end
      endcase
    end
  end

  mmrf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pixel_in  (pixel_in),
    .row_end   (row_end),
    .pix_valid (pix_valid),
    .full      (fifo_full),
    .pix_stall (pix_stall),
    .push      (push),
    .job       (push_job)
  );

  assign fifo_pop = job_ready && fifo_valid;

  mmrf_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_job),
    .pop   (fifo_pop),
    .valid (fifo_valid),
    .full  (fifo_full),
    .dout  (head_job)
  );

  mmrf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (fifo_valid),
    .job       (head_job),
    .job_ready (job_ready),
    .pixel_out (pixel_out),
    .row_done  (row_done),
    .res_valid (res_valid),
    .res_stall (res_stall)
  );

  // bookkeeping for checks: rows taken in but not yet closed out
  logic [PendBits-1:0] rows_pend;
  logic                seen_pix;
  logic                row_in;
  logic                row_out;

  assign row_in  = pix_valid && !pix_stall && row_end;
  assign row_out = res_valid && !res_stall && row_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_pend <= '0;
      seen_pix  <= 1'b0;
    end else begin
      if (pix_valid && !pix_stall) begin
        seen_pix <= 1'b1;
      end
      if (row_in && !row_out) begin
        rows_pend <= rows_pend + PendBits'(1);
      end else if (row_out && !row_in) begin
        rows_pend <= rows_pend - PendBits'(1);
      end
    end
  end

  // a row can only close after its row_end beat was taken
  a_row_done_pending: assert property (@(posedge clk) disable iff (rst)
    (res_valid && row_done) |-> (rows_pend != '0))
    else $error("row_done beat with no open row");

  // no result appears before any pixel has been taken
  a_no_result_before_input: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> seen_pix)
    else $error("result beat before any input beat");

  // the queue only stalls the input while the back end holds work
  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> fifo_valid)
    else $error("input stalled with an empty job queue");

endmodule

/* hdl/mmrf_front.sv */
// ----------------------------------------------------------------------------
// mmrf_front: input window and classifier
// Shifts each accepted pixel into the window, tracks the position in the
// row and turns the beat into a job for the back end.
// ----------------------------------------------------------------------------
module mmrf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  mmrf_pkg::cfg_t                cfg,
  input  logic [mmrf_pkg::PixBits-1:0]  pixel_in,
  input  logic                          row_end,
  input  logic                          pix_valid,
  input  logic                          full,
  output logic                          pix_stall,
  output logic                          push,
  output mmrf_pkg::job_t                job
);
  import mmrf_pkg::*;

  logic [WinLen-1:0][PixBits-1:0] win, win_next;
  logic [PosBits-1:0]             pos, pos_next;
  logic                           accept;
  logic                           past_half;

  assign pix_stall = full;
  assign accept    = pix_valid && !full;
  assign past_half = pos >= PosBits'(Half);

  // window after this beat: oldest at index 0, newest at the top
  always_comb begin
    for (int i = 0; i < WinLen - 1; i++) begin
      win_next[i] = win[i + 1];
    end
    win_next[WinLen-1] = pixel_in;
  end

  // classify the beat
  always_comb begin
    job.win      = win_next;
    job.has_main = past_half;
    job.filt     = (pos >= PosBits'(WinLen - 1)) &&
                   (cfg.region_rows >= RowsBits'(WinLen));
    if (!row_end) begin
      job.nflush = '0;
    end else if (past_half) begin
      job.nflush = FlushBits'(Half);
    end else begin
      job.nflush = FlushBits'(pos) + FlushBits'(1);
    end
  end

  // beats that emit nothing need no job
  assign push = accept && (past_half || row_end);

  // row position saturates on very long rows
  always_comb begin
    if (row_end) begin
      pos_next = '0;
    end else if (pos < PosBits'(PosCap)) begin
      pos_next = pos + PosBits'(1);
    end else begin
      pos_next = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= win_next;
    end
  end

endmodule

/* hdl/mmrf_fifo.sv */
// ----------------------------------------------------------------------------
// mmrf_fifo: job queue between front and back
// Small register queue that lets the input side keep going while the
// back end drains a row-end burst.
// ----------------------------------------------------------------------------
module mmrf_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mmrf_pkg::job_t din,
  input  logic           pop,
  output logic           valid,
  output logic           full,
  output mmrf_pkg::job_t dout
);
  import mmrf_pkg::*;

  job_t                   mem [FifoDepth];
  logic [FifoPtrBits-1:0] wr_ptr;
  logic [FifoPtrBits-1:0] rd_ptr;
  logic [FifoCntBits-1:0] count;

  assign valid = count != '0;
  assign full  = count == FifoCntBits'(FifoDepth);
  assign dout  = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FifoPtrBits'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FifoPtrBits'(1);
      end
      if (push && !pop) begin
        count <= count + FifoCntBits'(1);
      end else if (pop && !push) begin
        count <= count - FifoCntBits'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

/* hdl/mmrf_back.sv */
// ----------------------------------------------------------------------------
// mmrf_back: masked median pipeline and result sequencer
// Compare stage, rank stage, then an output stage that sends the centre
// beat and any row-end flush beats one per clock while res_stall is low.
// ----------------------------------------------------------------------------
module mmrf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  mmrf_pkg::cfg_t                cfg,
  input  logic                          job_valid,
  input  mmrf_pkg::job_t                job,
  output logic                          job_ready,
  output logic [mmrf_pkg::PixBits-1:0]  pixel_out,
  output logic                          row_done,
  output logic                          res_valid,
  input  logic                          res_stall
);
  import mmrf_pkg::*;

  // stage 1: pairwise order matrix and sample mask
  logic                           v1;
  logic [WinLen-1:0][WinLen-1:0]  before1;
  logic [WinLen-1:0]              mask1;
  logic [WinLen-1:0][PixBits-1:0] win1;
  logic                           has_main1;
  logic                           filt1;
  logic [FlushBits-1:0]           nflush1;

  // stage 2: one-hot median pick
  logic                           v2;
  logic [WinLen-1:0]              sel2;
  logic [WinLen-1:0][PixBits-1:0] win2;
  logic                           cmark2;
  logic                           has_main2;
  logic                           filt2;
  logic [FlushBits-1:0]           nflush2;

  // stage 3: result beats
  logic                           v3;
  pix_t                           main3;
  pix_t                           tail3 [Half];
  logic                           has_main3;
  logic [FlushBits-1:0]           nflush3;
  logic [FlushBits-1:0]           beat3;

  logic [WinLen-1:0][WinLen-1:0]  before_c;
  logic [WinLen-1:0]              mask_c;
  logic [RankBits-1:0]            cnt_c;
  logic [RankBits-1:0]            rank_c [WinLen];
  logic [WinLen-1:0]              sel_c;
  pix_t                           med_c;
  pix_t                           main_c;
  logic [FlushBits-1:0]           total3;
  logic [TailBits-1:0]            tail_idx;
  logic                           last3;
  logic                           fire;
  logic                           rdy1, rdy2, rdy3;

  // handshake between stages
  assign fire      = v3 && !res_stall;
  assign total3    = FlushBits'(has_main3) + nflush3;
  assign last3     = beat3 == (total3 - FlushBits'(1));
  assign rdy3      = !v3 || (fire && last3);
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign job_ready = rdy1;

  // strict order: j sorts before i, ties broken by position
  always_comb begin
    for (int i = 0; i < WinLen; i++) begin
      mask_c[i] = !(cfg.marker_enable && (job.win[i] == cfg.marker_value));
      for (int j = 0; j < WinLen; j++) begin
        if (j == i) begin
          before_c[i][j] = 1'b0;
        end else if (j < i) begin
          before_c[i][j] = job.win[j] <= job.win[i];
        end else begin
          before_c[i][j] = job.win[j] < job.win[i];
        end
      end
    end
  end

  // rank among unmarked samples; pick rank count/2 (upper median)
  always_comb begin
    cnt_c = RankBits'($countones(mask1));
    for (int i = 0; i < WinLen; i++) begin
      rank_c[i] = RankBits'($countones(before1[i] & mask1));
      sel_c[i]  = mask1[i] && (rank_c[i] == (cnt_c >> 1));
    end
  end

  // gather the picked sample and choose the centre result
  always_comb begin
    med_c = '0;
    for (int i = 0; i < WinLen; i++) begin
      if (sel2[i]) begin
        med_c = med_c | win2[i];
      end
    end
    if (!filt2) begin
      main_c = win2[Half];
    end else if (cmark2) begin
      main_c = cfg.marker_replace;
    end else begin
      main_c = med_c;
    end
  end

  // stage valids and beat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      beat3 <= '0;
    end else begin
      if (rdy1) begin
        v1 <= job_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3    <= v2;
        beat3 <= '0;
      end else if (fire) begin
        beat3 <= beat3 + FlushBits'(1);
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (rdy1 && job_valid) begin
      before1   <= before_c;
      mask1     <= mask_c;
      win1      <= job.win;
      has_main1 <= job.has_main;
      filt1     <= job.filt;
      nflush1   <= job.nflush;
    end
    if (rdy2 && v1) begin
      sel2      <= sel_c;
      win2      <= win1;
      cmark2    <= !mask1[Half];
      has_main2 <= has_main1;
      filt2     <= filt1;
      nflush2   <= nflush1;
    end
    if (rdy3 && v2) begin
      main3     <= main_c;
      has_main3 <= has_main2;
      nflush3   <= nflush2;
      for (int k = 0; k < Half; k++) begin
        tail3[k] <= win2[Half + 1 + k];
      end
    end
  end

  // flush beats read the newest nflush pixels, oldest first
  assign tail_idx  = TailBits'(FlushBits'(Half) - nflush3 + beat3 - FlushBits'(has_main3));
  assign res_valid = v3;
  assign row_done  = last3 && (nflush3 != '0);
  assign pixel_out = (has_main3 && (beat3 == '0)) ? main3 : tail3[tail_idx];

endmodule
